### rtl/slom_pkg.sv
`default_nettype none
package slom_pkg;

  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int IN_LVL_W  = 3;

  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FS_NONE,
    FS_POP,
    FS_PUSH
  } fs_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LINK,
    S_LINKW,
    S_KEY,
    S_DECIDE,
    S_POPW,
    S_INS_A,
    S_INS_B,
    S_DEL_RD,
    S_DEL_WR,
    S_PUSH,
    S_TRIM,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/slom_ram.sv
`default_nettype none
module slom_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/slom_free_stack.sv
`default_nettype none
module slom_free_stack
  import slom_pkg::*;
#(
  parameter int NODE_COUNT = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fs_op_t                        op,
  input  wire logic [$clog2(NODE_COUNT)-1:0] push_node,
  output logic      [$clog2(NODE_COUNT)-1:0] pop_node,
  output logic                               empty
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);

  // Entries below the lowest count ever reached were never written; a pop
  // from one of them returns its own index instead of the RAM word.
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  wm_r, wm_nxt;
  logic              low_r, low_nxt;
  logic [NODE_W-1:0] addr_r, addr_nxt;
  logic              we;
  logic [NODE_W-1:0] ram_addr;
  logic [NODE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  cnt_dec;

  assign cnt_dec = cnt_r - CNT_W'(1);
  assign empty   = (cnt_r == '0);

  always_comb begin
    cnt_nxt  = cnt_r;
    wm_nxt   = wm_r;
    low_nxt  = low_r;
    addr_nxt = addr_r;
    we       = 1'b0;
    ram_addr = cnt_dec[NODE_W-1:0];
    case (op)
      FS_POP: begin
        cnt_nxt  = cnt_dec;
        low_nxt  = (cnt_dec < wm_r);
        addr_nxt = cnt_dec[NODE_W-1:0];
        if (cnt_dec < wm_r) begin
          wm_nxt = cnt_dec;
        end
      end
      FS_PUSH: begin
        if (cnt_r < CNT_W'(NODE_COUNT)) begin
          ram_addr = cnt_r[NODE_W-1:0];
          we       = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(NODE_COUNT);
      wm_r  <= CNT_W'(NODE_COUNT);
      low_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wm_r  <= wm_nxt;
      low_r <= low_nxt;
    end
    addr_r <= addr_nxt;
  end

  slom_ram #(.DATA_W(NODE_W), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (push_node),
    .rdata (ram_rdata)
  );

  assign pop_node = low_r ? addr_r : ram_rdata;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == FS_POP) |-> (cnt_r != '0))
    else $error("pop from empty free stack");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NODE_COUNT))
    else $error("free count above pool size");
  a_wm_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wm_r <= cnt_r)
    else $error("watermark above free count");

endmodule
`default_nettype wire

### rtl/skip_list_ordered_map.sv
`default_nettype none
// Ordered map from signed 32-bit keys to 32-bit payloads, kept as a skip
// list in a fixed pool of nodes.
// Input channel: one beat per request (in_action search/insert/delete,
// in_key, in_payload, in_insert_level), accepted when in_valid is high and
// in_stall is low. Result channel: one beat per request (out_status,
// out_found, out_read_payload) under out_valid/out_stall.
// Requests are handled one at a time. Each visited link in the top-down
// walk takes a link read, a key read and a compare; insert adds a link write
// for the new node and a predecessor update per linked level, delete adds a
// link read and a predecessor update per unlinked level, and delete ends
// with a push to the free pool and a top-level trim. Both memories are single-port.
// The result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, a finished request waits until
// the output register empties, and in_stall stays high meanwhile.
// Reset empties the map and refills the free pool at once; no clearing
// pass is needed, so requests are accepted as soon as reset is released.
module skip_list_ordered_map
  import slom_pkg::*;
#(
  parameter int NODE_COUNT = 256,
  parameter int LEVEL_MAX  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic [PAY_W-1:0]     in_payload,
  input  wire logic [IN_LVL_W-1:0]  in_insert_level,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic                      out_found,
  output logic [PAY_W-1:0]          out_read_payload
);

  localparam int LEVELS = LEVEL_MAX + 1;
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int LINK_W = $clog2(NODE_COUNT + 2);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int LA_W   = $clog2(NODE_COUNT * LEVELS);
  localparam logic [LINK_W-1:0] NIL  = LINK_W'(NODE_COUNT);
  localparam logic [LINK_W-1:0] HEAD = LINK_W'(NODE_COUNT + 1);

  state_t state_r, state_nxt;

  // Request registers.
  action_t                  act_r, act_nxt;
  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic [PAY_W-1:0]         pay_r, pay_nxt;
  logic [LVL_W-1:0]         lvl_r, lvl_nxt;

  // Walk state: current node, candidate next node and level.
  logic [LINK_W-1:0] x_r, x_nxt;
  logic [LINK_W-1:0] nx_r, nx_nxt;
  logic [LVL_W-1:0]  i_r, i_nxt;
  logic [LINK_W-1:0] pred_r [LEVELS];
  logic [LINK_W-1:0] pred_nxt [LEVELS];
  logic [LINK_W-1:0] succ_r [LEVELS];
  logic [LINK_W-1:0] succ_nxt [LEVELS];
  logic              hit_r, hit_nxt;
  logic [PAY_W-1:0]  hpay_r, hpay_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;

  // List head and top level live in flip-flops.
  logic [LINK_W-1:0] hdr_r [LEVELS];
  logic [LINK_W-1:0] hdr_nxt [LEVELS];
  logic [LVL_W-1:0]  top_r, top_nxt;

  // Result.
  status_t          st_r, st_nxt;
  logic             fd_r, fd_nxt;
  logic [PAY_W-1:0] rd_r, rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_found_r, out_found_nxt;
  logic [PAY_W-1:0] out_rd_r, out_rd_nxt;

  // Memory ports.
  logic                     kmem_we;
  logic [NODE_W-1:0]        kmem_addr;
  logic [KEY_W+PAY_W-1:0]   kmem_rdata;
  logic                     lmem_we;
  logic [LA_W-1:0]          lmem_addr;
  logic [LINK_W-1:0]        lmem_wdata;
  logic [LINK_W-1:0]        lmem_rdata;
  fs_op_t                   fs_op;
  logic [NODE_W-1:0]        fs_push_node;
  logic [NODE_W-1:0]        fs_pop_node;
  logic                     fs_empty;

  logic signed [KEY_W-1:0]  rd_key;
  logic [PAY_W-1:0]         rd_pay;
  logic [LINK_W-1:0]        walk_nx;
  logic                     in_take;

  assign rd_key  = kmem_rdata[KEY_W+PAY_W-1:PAY_W];
  assign rd_pay  = kmem_rdata[PAY_W-1:0];
  assign in_take = in_valid && !in_stall;
  assign walk_nx = (x_r == HEAD) ? hdr_r[i_r] : lmem_rdata;

  function automatic logic [LA_W-1:0] link_addr(input logic [LINK_W-1:0] n,
                                                input logic [LVL_W-1:0] l);
    logic [LA_W-1:0] base;
    base = (n >= LINK_W'(NODE_COUNT)) ? '0 : LA_W'(n);
    return LA_W'(base * LA_W'(LEVELS)) + LA_W'(l);
  endfunction

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    lvl_nxt        = lvl_r;
    x_nxt          = x_r;
    nx_nxt         = nx_r;
    i_nxt          = i_r;
    pred_nxt       = pred_r;
    succ_nxt       = succ_r;
    hit_nxt        = hit_r;
    hpay_nxt       = hpay_r;
    node_nxt       = node_r;
    hdr_nxt        = hdr_r;
    top_nxt        = top_r;
    st_nxt         = st_r;
    fd_nxt         = fd_r;
    rd_nxt         = rd_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_rd_nxt     = out_rd_r;
    out_valid_nxt  = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    kmem_we        = 1'b0;
    kmem_addr      = walk_nx[NODE_W-1:0];
    lmem_we        = 1'b0;
    lmem_addr      = link_addr(x_r, i_r);
    lmem_wdata     = succ_r[i_r];
    fs_op          = FS_NONE;
    fs_push_node   = x_r[NODE_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          act_nxt = action_t'(in_action);
          key_nxt = in_key;
          pay_nxt = in_payload;
          lvl_nxt = (in_insert_level > IN_LVL_W'(LEVEL_MAX)) ?
                    LVL_W'(LEVEL_MAX) : LVL_W'(in_insert_level);
          x_nxt   = HEAD;
          i_nxt   = top_r;
          hit_nxt = 1'b0;
          for (int l = 0; l < LEVELS; l++) begin
            pred_nxt[l] = HEAD;
            succ_nxt[l] = NIL;
          end
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        lmem_addr = link_addr(x_r, i_r);
        state_nxt = S_LINKW;
      end
      S_LINKW: begin
        if (walk_nx == NIL) begin
          pred_nxt[i_r] = x_r;
          succ_nxt[i_r] = NIL;
          if (i_r == '0) begin
            hit_nxt   = 1'b0;
            state_nxt = S_DECIDE;
          end else begin
            i_nxt     = i_r - LVL_W'(1);
            state_nxt = S_LINK;
          end
        end else begin
          kmem_addr = walk_nx[NODE_W-1:0];
          nx_nxt    = walk_nx;
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        if (rd_key >= key_r) begin
          pred_nxt[i_r] = x_r;
          succ_nxt[i_r] = nx_r;
          if (i_r == '0) begin
            hit_nxt   = (rd_key == key_r);
            hpay_nxt  = rd_pay;
            state_nxt = S_DECIDE;
          end else begin
            i_nxt     = i_r - LVL_W'(1);
            state_nxt = S_LINK;
          end
        end else begin
          x_nxt     = nx_r;
          state_nxt = S_LINK;
        end
      end
      S_DECIDE: begin
        st_nxt    = ST_NOT_FOUND;
        fd_nxt    = 1'b0;
        rd_nxt    = '0;
        state_nxt = S_DONE;
        case (act_r)
          ACT_SEARCH: begin
            if (hit_r) begin
              st_nxt = ST_OK;
              fd_nxt = 1'b1;
              rd_nxt = hpay_r;
            end
          end
          ACT_INSERT: begin
            if (hit_r) begin
              st_nxt = ST_DUPLICATE;
              fd_nxt = 1'b1;
            end else if (fs_empty) begin
              st_nxt = ST_POOL_FULL;
            end else begin
              fs_op     = FS_POP;
              state_nxt = S_POPW;
            end
          end
          ACT_DELETE: begin
            if (hit_r) begin
              x_nxt     = succ_r[0];
              i_nxt     = '0;
              state_nxt = S_DEL_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPW: begin
        node_nxt  = fs_pop_node;
        kmem_we   = 1'b1;
        kmem_addr = fs_pop_node;
        if (lvl_r > top_r) begin
          top_nxt = lvl_r;
        end
        i_nxt     = '0;
        state_nxt = S_INS_A;
      end
      S_INS_A: begin
        // New node points at the old successor on this level.
        lmem_we    = 1'b1;
        lmem_addr  = link_addr(LINK_W'(node_r), i_r);
        lmem_wdata = succ_r[i_r];
        state_nxt  = S_INS_B;
      end
      S_INS_B: begin
        if (pred_r[i_r] == HEAD) begin
          hdr_nxt[i_r] = LINK_W'(node_r);
        end else begin
          lmem_we    = 1'b1;
          lmem_addr  = link_addr(pred_r[i_r], i_r);
          lmem_wdata = LINK_W'(node_r);
        end
        if (i_r == lvl_r) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + LVL_W'(1);
          state_nxt = S_INS_A;
        end
      end
      S_DEL_RD: begin
        if (i_r > top_r || succ_r[i_r] != x_r) begin
          state_nxt = S_PUSH;
        end else begin
          lmem_addr = link_addr(x_r, i_r);
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        if (pred_r[i_r] == HEAD) begin
          hdr_nxt[i_r] = lmem_rdata;
        end else begin
          lmem_we    = 1'b1;
          lmem_addr  = link_addr(pred_r[i_r], i_r);
          lmem_wdata = lmem_rdata;
        end
        if (i_r == top_r) begin
          state_nxt = S_PUSH;
        end else begin
          i_nxt     = i_r + LVL_W'(1);
          state_nxt = S_DEL_RD;
        end
      end
      S_PUSH: begin
        fs_op        = FS_PUSH;
        fs_push_node = x_r[NODE_W-1:0];
        state_nxt    = S_TRIM;
      end
      S_TRIM: begin
        if (top_r != '0 && hdr_r[top_r] == NIL) begin
          top_nxt = top_r - LVL_W'(1);
        end else begin
          st_nxt    = ST_OK;
          fd_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_found_nxt  = fd_r;
          out_rd_nxt     = rd_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        hdr_r[l] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      hdr_r       <= hdr_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    lvl_r        <= lvl_nxt;
    x_r          <= x_nxt;
    nx_r         <= nx_nxt;
    i_r          <= i_nxt;
    pred_r       <= pred_nxt;
    succ_r       <= succ_nxt;
    hit_r        <= hit_nxt;
    hpay_r       <= hpay_nxt;
    node_r       <= node_nxt;
    st_r         <= st_nxt;
    fd_r         <= fd_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  // Key and payload of each node share one word.
  slom_ram #(.DATA_W(KEY_W + PAY_W), .DEPTH(NODE_COUNT)) u_kmem (
    .clk   (clk),
    .we    (kmem_we),
    .addr  (kmem_addr),
    .wdata ({key_r, pay_r}),
    .rdata (kmem_rdata)
  );

  // Forward link of node n at level l sits at n * LEVELS + l.
  slom_ram #(.DATA_W(LINK_W), .DEPTH(NODE_COUNT * LEVELS)) u_lmem (
    .clk   (clk),
    .we    (lmem_we),
    .addr  (lmem_addr),
    .wdata (lmem_wdata),
    .rdata (lmem_rdata)
  );

  slom_free_stack #(.NODE_COUNT(NODE_COUNT)) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (fs_op),
    .push_node (fs_push_node),
    .pop_node  (fs_pop_node),
    .empty     (fs_empty)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_read_payload = out_rd_r;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LVL_W'(LEVEL_MAX))
    else $error("top level above maximum");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");
  a_take_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_LINK))
    else $error("accepted request did not start a walk");

endmodule
`default_nettype wire
